@@ rtl/core/gtov_pkg.sv @@
// Shared types, widths and codes of the gamma tap offset to voltage converter.
package gtov_pkg;

	// Field widths of the stream payloads
	localparam int TAP_W      = 4;
	localparam int COLOR_W    = 2;
	localparam int BASE_W     = 9;
	localparam int OFF_W      = 10;
	localparam int COEF_W     = 10;
	localparam int VOLT_W     = 48;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_USER_W = 3;

	// Configuration registers
	localparam int REF_W     = 32;
	localparam int TCNT_W    = 5;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_REF_VOLTAGE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = 2'd1;
	localparam logic [TCNT_W-1:0]    TCNT_RESET      = 5'd9;

	// Datapath sizing
	localparam int ACC_W     = 62;  // adder width, holds ref minus any signed quotient
	localparam int PROD_W    = 60;  // product and quotient magnitude
	localparam int MUL_W     = 11;  // multiplier magnitude
	localparam int REM_W     = 10;  // divider remainder
	localparam int STEP_W    = 6;
	localparam int MUL_STEPS = 11;
	localparam int DIV_STEPS = 60;
	localparam int CNT_W     = 6;   // effective tap count, at most MAX_TAPS
	localparam int ADDR_W    = 7;   // tap*3+color before trimming to the memory depth

	localparam int NUM_COLORS  = 3;
	localparam int BLACK_DEPTH = 16;

	localparam logic [VOLT_W-1:0] VOLT_MAX = {1'b0, {(VOLT_W-1){1'b1}}};
	localparam logic [VOLT_W-1:0] VOLT_MIN = {1'b1, {(VOLT_W-1){1'b0}}};

	localparam logic               OP_LOAD    = 1'b0;
	localparam logic               OP_CONVERT = 1'b1;
	localparam logic [COLOR_W-1:0] COLOR_NONE = 2'd3;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_TAP   = 2'd1,
		ERR_BLACK = 2'd2
	} err_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD0,
		ST_RD1,
		ST_SPAN,
		ST_ABS,
		ST_MUL,
		ST_DIV,
		ST_NEG,
		ST_FIN,
		ST_PUSH
	} state_t;

	// Flat tap voltage address: tap * 3 + color
	function automatic logic [ADDR_W-1:0] tap_addr(input logic [TAP_W:0] tap,
		input logic [COLOR_W-1:0] color);
		logic [ADDR_W-1:0] t;
		t = ADDR_W'(tap);
		return t + t + t + ADDR_W'(color);
	endfunction

endpackage

@@ rtl/core/gtov_tapmem.sv @@
// Tap voltage memory with per-entry valid bits; unwritten entries read as zero.
module gtov_tapmem
	import gtov_pkg::*;
#(
	parameter int DEPTH = 48
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [$clog2(DEPTH)-1:0]        rd_addr,
	output logic [VOLT_W-1:0]               rd_data,
	input  logic                            wr_en,
	input  logic [$clog2(DEPTH)-1:0]        wr_addr,
	input  logic [VOLT_W-1:0]               wr_data
);

	logic [VOLT_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [VOLT_W-1:0] rd_data_q;
	logic              rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

@@ rtl/core/gamma_tap_offset_to_voltage.sv @@
// Top level: gamma tap offset to voltage converter with shared iterative adder.
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------------
//  cfg      | in        | cfg_index (0 ref_voltage, 1 tap_count), cfg_data
//  s_axis   | in        | tuser: opcode; tdata: index,color,base,offset,num,den
//  m_axis   | out       | tdata: voltage; tuser: negative, error
//
// A load beat or an ignored color-three beat is taken without leaving idle. A convert beat
// holds off the next beat until it is through: after its accept come four memory read and
// setup steps, 11 shift-add multiply steps, 60 restoring divide steps and three finishing
// steps, with the arithmetic on one 62-bit adder. Error results go from the accept straight
// to the push step. Reset clears the tap voltage valid bits and the black table at
// once; a finished result waits in the output register, and the next beat is taken
// meanwhile. The last step holds while the output register is full and not taken.
module gamma_tap_offset_to_voltage
	import gtov_pkg::*;
#(
	parameter int MAX_TAPS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [REF_W-1:0]      cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [3:0] index, [5:4] color, [14:6] base, [24:15] offset, [34:25] coef_num,
	// [44:35] coef_den, [47:45] zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [0] opcode
	input  logic [0:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [47:0] voltage
	output logic [VOLT_W-1:0]     m_axis_tdata,
	// [0] negative, [2:1] error
	output logic [OUT_USER_W-1:0] m_axis_tuser
);

	localparam int TV_DEPTH = MAX_TAPS * NUM_COLORS;
	localparam int TV_AW    = $clog2(TV_DEPTH);

	// Input fields
	logic [TAP_W-1:0]   in_index;
	logic [COLOR_W-1:0] in_color;
	logic [BASE_W-1:0]  in_base;
	logic [OFF_W-1:0]   in_offset;
	logic [COEF_W-1:0]  in_num;
	logic [COEF_W-1:0]  in_den;

	assign in_index  = s_axis_tdata[3:0];
	assign in_color  = s_axis_tdata[5:4];
	assign in_base   = s_axis_tdata[14:6];
	assign in_offset = s_axis_tdata[24:15];
	assign in_num    = s_axis_tdata[34:25];
	assign in_den    = s_axis_tdata[44:35];

	state_t state_q, state_d;

	logic [REF_W-1:0]  ref_q;
	logic [TCNT_W-1:0] tap_count_q;
	logic [COEF_W-1:0] black_q [BLACK_DEPTH];
	logic [STEP_W-1:0] step_q;

	logic [TAP_W-1:0]   v_q;
	logic [COLOR_W-1:0] c_q;
	logic [COEF_W-1:0]  den_q;
	logic               use_ref_q;
	logic               use_b_q;
	logic               mneg_q;
	logic               neg_q;
	logic [MUL_W-1:0]   mplier_q;
	logic [PROD_W-1:0]  mcand_q;
	logic [PROD_W-1:0]  acc_q;
	logic [REM_W-1:0]   rem_q;
	logic [ACC_W-1:0]   a_q;
	logic [ACC_W-1:0]   t_q;
	logic [VOLT_W-1:0]  res_volt_q;
	logic               res_neg_q;
	err_t               res_err_q;

	logic               out_valid_q;
	logic [VOLT_W-1:0]  out_volt_q;
	logic               out_neg_q;
	err_t               out_err_q;

	// Accept-time decode
	logic              in_acc;
	logic              in_conv;
	logic              in_err;
	err_t              in_err_code;
	logic [CNT_W-1:0]  tap_cnt;
	logic [CNT_W-1:0]  tap_ext;
	logic              is_tap0;
	logic              is_top;
	logic              is_tap1;
	logic [BASE_W+1:0] bidx;
	logic              bidx_bad;
	logic [MUL_W:0]    ratio;
	logic [MUL_W:0]    ratio_neg;
	logic [MUL_W-1:0]  ratio_mag;
	logic [COEF_W-1:0] black_val;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign in_conv       = in_acc && (s_axis_tuser[0] == OP_CONVERT) && (in_color != COLOR_NONE);

	assign tap_cnt  = ({1'b0, tap_count_q} > CNT_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS)
		: {1'b0, tap_count_q};
	assign tap_ext  = CNT_W'(in_index);
	assign is_tap0  = (in_index == '0);
	assign is_top   = ((tap_ext + CNT_W'(1)) == tap_cnt);
	assign is_tap1  = (in_index == TAP_W'(1));

	assign bidx      = {2'b00, in_base} + {in_offset[OFF_W-1], in_offset};
	assign bidx_bad  = bidx[BASE_W+1] || (bidx[BASE_W:4] != '0);
	assign ratio     = {2'b00, in_num} + {3'b000, in_base} + {{2{in_offset[OFF_W-1]}}, in_offset};
	assign ratio_neg = '0 - ratio;
	assign ratio_mag = ratio[MUL_W] ? ratio_neg[MUL_W-1:0] : ratio[MUL_W-1:0];
	assign black_val = black_q[bidx[3:0]];

	always_comb begin
		in_err_code = ERR_OK;
		if (tap_ext >= tap_cnt) begin
			in_err_code = ERR_TAP;
		end else if (is_tap0 && bidx_bad) begin
			in_err_code = ERR_BLACK;
		end
	end
	assign in_err = (in_err_code != ERR_OK);

	// Tap voltage memory
	logic [ADDR_W-1:0] cur_addr_w;
	logic [ADDR_W-1:0] anc_addr_w;
	logic [ADDR_W-1:0] nxt_addr_w;
	logic [TV_AW-1:0]  rd_addr;
	logic [VOLT_W-1:0] tv_rd;
	logic [ACC_W-1:0]  tv_ext;
	logic              tv_wr_en;
	logic [VOLT_W-1:0] sat_val;

	assign cur_addr_w = tap_addr({1'b0, v_q}, c_q);
	// tap 0 of the same color anchors the interpolation
	assign anc_addr_w = tap_addr('0, c_q);
	assign nxt_addr_w = tap_addr({1'b0, v_q} + 5'd1, c_q);
	assign rd_addr    = (state_q == ST_RD1 && use_b_q) ? nxt_addr_w[TV_AW-1:0]
		: anc_addr_w[TV_AW-1:0];
	assign tv_ext     = {{(ACC_W-VOLT_W){tv_rd[VOLT_W-1]}}, tv_rd};
	assign tv_wr_en   = (state_q == ST_FIN);

	gtov_tapmem #(
		.DEPTH(TV_DEPTH)
	) u_tapmem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_addr(rd_addr),
		.rd_data(tv_rd),
		.wr_en  (tv_wr_en),
		.wr_addr(cur_addr_w[TV_AW-1:0]),
		.wr_data(sat_val)
	);

	// Shared adder: span, magnitude, multiply accumulate, trial subtract, sign, final
	logic [ACC_W-1:0]  add_a;
	logic [ACC_W-1:0]  add_b;
	logic              add_cin;
	logic [ACC_W-1:0]  add_sum;
	logic [REM_W:0]    div_shift;
	logic              div_qbit;
	logic [ACC_W-1:0]  q_ext;
	logic              mul_last;
	logic              div_last;
	logic              out_free;
	logic              sat_hi;
	logic              sat_lo;

	assign div_shift = {rem_q, acc_q[PROD_W-1]};
	assign q_ext     = (den_q == '0) ? '0 : ACC_W'(acc_q);

	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_cin = 1'b0;
		unique case (state_q)
			ST_SPAN: begin
				add_a   = a_q;
				add_b   = ~(use_b_q ? tv_ext : '0);
				add_cin = 1'b1;
			end
			ST_ABS: begin
				add_b   = ~t_q;
				add_cin = 1'b1;
			end
			ST_MUL: begin
				add_a = ACC_W'(acc_q);
				add_b = mplier_q[0] ? ACC_W'(mcand_q) : '0;
			end
			ST_DIV: begin
				add_a   = ACC_W'(div_shift);
				add_b   = ~ACC_W'(den_q);
				add_cin = 1'b1;
			end
			ST_NEG: begin
				add_b   = ~q_ext;
				add_cin = 1'b1;
			end
			ST_FIN: begin
				add_a   = a_q;
				add_b   = ~t_q;
				add_cin = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign add_sum  = add_a + add_b + ACC_W'(add_cin);
	assign div_qbit = !add_sum[ACC_W-1];

	// Clamp the final difference to the 48-bit signed range
	assign sat_hi  = !add_sum[ACC_W-1] && (add_sum[ACC_W-2:VOLT_W-1] != '0);
	assign sat_lo  = add_sum[ACC_W-1] && (add_sum[ACC_W-2:VOLT_W-1] != '1);
	assign sat_val = sat_hi ? VOLT_MAX : (sat_lo ? VOLT_MIN : add_sum[VOLT_W-1:0]);

	assign mul_last = (step_q == STEP_W'(MUL_STEPS - 1));
	assign div_last = (step_q == STEP_W'(DIV_STEPS - 1));
	assign out_free = !out_valid_q || m_axis_tready;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_conv) begin
					state_d = in_err ? ST_PUSH : ST_RD0;
				end
			end
			ST_RD0:  state_d = ST_RD1;
			ST_RD1:  state_d = ST_SPAN;
			ST_SPAN: state_d = ST_ABS;
			ST_ABS:  state_d = ST_MUL;
			ST_MUL: begin
				if (mul_last) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_last) begin
					state_d = ST_NEG;
				end
			end
			ST_NEG:  state_d = ST_FIN;
			ST_FIN:  state_d = ST_PUSH;
			ST_PUSH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else begin
			unique case (state_q)
				ST_ABS:  step_q <= '0;
				ST_MUL:  step_q <= mul_last ? '0 : step_q + 1'b1;
				ST_DIV:  step_q <= step_q + 1'b1;
				default: begin
				end
			endcase
		end
	end

	// Configuration and black coefficient table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q       <= '0;
			tap_count_q <= TCNT_RESET;
			black_q     <= '{default: '0};
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_REF_VOLTAGE: ref_q       <= cfg_data;
					REG_TAP_COUNT:   tap_count_q <= cfg_data[TCNT_W-1:0];
					default: begin
					end
				endcase
			end
			if (in_acc && (s_axis_tuser[0] == OP_LOAD)) begin
				black_q[in_index] <= in_num;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_conv) begin
			v_q        <= in_index;
			c_q        <= in_color;
			den_q      <= in_den;
			use_ref_q  <= is_tap0 || is_top || is_tap1;
			use_b_q    <= !is_tap0 && !is_top;
			mplier_q   <= is_tap0 ? MUL_W'(black_val) : ratio_mag;
			mneg_q     <= !is_tap0 && ratio[MUL_W];
			res_err_q  <= in_err_code;
			res_volt_q <= '0;
			res_neg_q  <= 1'b0;
		end
		unique case (state_q)
			ST_RD1:  a_q <= use_ref_q ? ACC_W'(ref_q) : tv_ext;
			ST_SPAN: t_q <= add_sum;
			ST_ABS: begin
				mcand_q <= t_q[ACC_W-1] ? add_sum[PROD_W-1:0] : t_q[PROD_W-1:0];
				neg_q   <= t_q[ACC_W-1] ^ mneg_q;
				acc_q   <= '0;
				rem_q   <= '0;
			end
			ST_MUL: begin
				acc_q    <= add_sum[PROD_W-1:0];
				mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
				mplier_q <= mplier_q >> 1;
			end
			ST_DIV: begin
				// shift the quotient bit in behind the dividend
				acc_q <= {acc_q[PROD_W-2:0], div_qbit};
				rem_q <= div_qbit ? add_sum[REM_W-1:0] : div_shift[REM_W-1:0];
			end
			ST_NEG:  t_q <= neg_q ? add_sum : q_ext;
			ST_FIN: begin
				res_volt_q <= sat_val;
				res_neg_q  <= add_sum[ACC_W-1];
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_PUSH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PUSH && out_free) begin
			out_volt_q <= res_volt_q;
			out_neg_q  <= res_neg_q;
			out_err_q  <= res_err_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_volt_q;
	assign m_axis_tuser  = {out_err_q, out_neg_q};

`ifndef NO_ASSERTIONS
	a_neg_matches_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[0] == m_axis_tdata[VOLT_W-1]))
		else $error("negative flag disagrees with voltage sign");

	a_err_zero_volt: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser[2:1] != ERR_OK)) |-> (m_axis_tdata == '0))
		else $error("error result carries a nonzero voltage");

	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_LOAD))
		|=> (state_q == ST_IDLE))
		else $error("load beat left the idle state");

	a_div_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (step_q < STEP_W'(DIV_STEPS)))
		else $error("divider step count overran");
`endif

endmodule
